// ===== sv/sfms_pkg.sv =====
// ----------------------------------------------------------------------------
// sfms_pkg
// Types, register indexes and byte helpers for the substring first-match search.
// ----------------------------------------------------------------------------
package sfms_pkg;

    localparam int CFG_INDEX_BITS    = 2;
    localparam int CFG_DATA_BITS     = 64;
    localparam int NEEDLE_CAP        = 16;
    localparam int NEEDLE_BITS       = 8 * NEEDLE_CAP;
    localparam int LEN_BITS          = 5;
    localparam int MATCH_OFFSET_BITS = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_NEEDLE_LOW    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NEEDLE_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NEEDLE_LENGTH = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CASE_FOLD     = 2'd3;

    localparam logic [7:0] UPPER_FIRST = 8'h41;
    localparam logic [7:0] UPPER_LAST  = 8'h5A;
    localparam logic [7:0] CASE_SHIFT  = 8'd32;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } haystack_t;

    typedef struct packed {
        logic                         found;
        logic [MATCH_OFFSET_BITS-1:0] match_offset;
    } result_t;

    typedef struct packed {
        logic [NEEDLE_BITS-1:0] needle;
        logic [LEN_BITS-1:0]    needle_length;
        logic                   case_fold;
    } cfg_t;

    // Lower ASCII capitals only when folding is on
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold_en);
        logic [7:0] r;
        r = c;
        if (fold_en && (c >= UPPER_FIRST) && (c <= UPPER_LAST))
        begin
            r = c + CASE_SHIFT;
        end
        return r;
    endfunction

endpackage

// ===== sv/sfms_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sfms_cfg_regs
// Configuration register file: needle bytes, needle length and case folding.
// ----------------------------------------------------------------------------
module sfms_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sfms_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sfms_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output sfms_pkg::cfg_t                       cfg
);

    localparam int HALF = sfms_pkg::NEEDLE_BITS / 2;

    sfms_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sfms_pkg::CFG_NEEDLE_LOW:
                begin
                    cfg_reg.needle[HALF-1:0] <= cfg_data[HALF-1:0];
                end
                sfms_pkg::CFG_NEEDLE_HIGH:
                begin
                    cfg_reg.needle[2*HALF-1:HALF] <= cfg_data[HALF-1:0];
                end
                sfms_pkg::CFG_NEEDLE_LENGTH:
                begin
                    cfg_reg.needle_length <= cfg_data[sfms_pkg::LEN_BITS-1:0];
                end
                sfms_pkg::CFG_CASE_FOLD:
                begin
                    cfg_reg.case_fold <= cfg_data[0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

endmodule

// ===== sv/sfms_in_reg.sv =====
// ----------------------------------------------------------------------------
// sfms_in_reg
// Input register: captures one haystack byte per cycle and holds it while the
// result side is blocked.
// ----------------------------------------------------------------------------
module sfms_in_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 haystack_valid,
    output logic                 haystack_stall,
    input  sfms_pkg::haystack_t  haystack,
    input  logic                 advance,
    output logic                 fire,
    output sfms_pkg::haystack_t  item
);

    logic                valid_reg;
    sfms_pkg::haystack_t data_reg;

    assign haystack_stall = valid_reg && !advance;
    assign fire           = valid_reg && advance;
    assign item           = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!haystack_stall)
        begin
            valid_reg <= haystack_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!haystack_stall && haystack_valid)
        begin
            data_reg <= haystack;
        end
    end

endmodule

// ===== sv/sfms_core.sv =====
// ----------------------------------------------------------------------------
// sfms_core
// Window of recent bytes, byte counter and answered flag, with the combinational
// needle compare on the registered byte.
// ----------------------------------------------------------------------------
module sfms_core
#(
    parameter int MAX_NEEDLE  = 16,
    parameter int OFFSET_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  sfms_pkg::cfg_t      cfg,
    input  logic                fire,
    input  sfms_pkg::haystack_t item,
    output logic                emit,
    output sfms_pkg::result_t   res
);

    localparam int WIN_DEPTH = MAX_NEEDLE - 1;
    localparam int CAP       = (MAX_NEEDLE < sfms_pkg::NEEDLE_CAP) ? MAX_NEEDLE
                                                                   : sfms_pkg::NEEDLE_CAP;
    localparam int LB        = sfms_pkg::LEN_BITS;
    localparam int MB        = sfms_pkg::MATCH_OFFSET_BITS;

    logic [7:0]             window_reg [WIN_DEPTH];
    logic [OFFSET_BITS-1:0] count_reg;
    logic                   answered_reg;

    logic [LB-1:0]          used_len;
    logic [LB-1:0]          len_m1;
    logic [7:0]             hay [CAP];
    logic [CAP-1:0]         byte_ok;
    logic                   count_ok;
    logic                   hit;
    logic [OFFSET_BITS-1:0] off;
    logic [OFFSET_BITS+MB-1:0] off_ext;

    always_comb
    begin
        used_len = cfg.needle_length;
        if (cfg.needle_length > LB'(CAP))
        begin
            used_len = LB'(CAP);
        end
        len_m1 = used_len - LB'(1);
    end

    always_comb
    begin
        hay[0] = item.data_byte;
        for (int k = 1; k < CAP; k++)
        begin
            hay[k] = window_reg[k-1];
        end
    end

    // Byte k back from the newest meets needle byte len-1-k
    always_comb
    begin
        logic [LB-1:0] idx;
        idx     = '0;
        byte_ok = '1;
        for (int k = 0; k < CAP; k++)
        begin
            if (LB'(k) < used_len)
            begin
                idx        = len_m1 - LB'(k);
                byte_ok[k] = sfms_pkg::fold_byte(hay[k], cfg.case_fold)
                             == cfg.needle[8*idx[3:0] +: 8];
            end
        end
    end

    always_comb
    begin
        count_ok = count_reg >= OFFSET_BITS'(len_m1);
        hit      = (used_len == '0) || (count_ok && (&byte_ok));
        off      = (used_len == '0) ? '0 : (count_reg - OFFSET_BITS'(len_m1));
        off_ext  = {{MB{1'b0}}, off};
        emit     = fire && !answered_reg && (hit || item.last_byte);
        res.found        = hit;
        res.match_offset = hit ? off_ext[MB-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                window_reg[i] <= '0;
            end
            count_reg    <= '0;
            answered_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (item.last_byte)
            begin
                // end of haystack: start afresh
                for (int i = 0; i < WIN_DEPTH; i++)
                begin
                    window_reg[i] <= '0;
                end
                count_reg    <= '0;
                answered_reg <= 1'b0;
            end
            else
            begin
                for (int i = 1; i < WIN_DEPTH; i++)
                begin
                    window_reg[i] <= window_reg[i-1];
                end
                window_reg[0] <= item.data_byte;
                if (count_reg != '1)
                begin
                    count_reg <= count_reg + OFFSET_BITS'(1);
                end
                answered_reg <= answered_reg || hit;
            end
        end
    end

endmodule

// ===== sv/sfms_out_reg.sv =====
// ----------------------------------------------------------------------------
// sfms_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module sfms_out_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               emit,
    input  sfms_pkg::result_t  res,
    output logic               advance,
    output logic               result_valid,
    input  logic               result_stall,
    output sfms_pkg::result_t  result
);

    logic              valid_reg;
    sfms_pkg::result_t data_reg;

    // slot is free, or drains this cycle
    assign advance      = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign result       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            data_reg <= res;
        end
    end

endmodule

// ===== sv/substring_first_match_search_top.sv =====
// ----------------------------------------------------------------------------
// substring_first_match_search_top
// Streaming search for the first occurrence of a configured needle.
// ----------------------------------------------------------------------------
// Haystack bytes arrive on the haystack channel (valid/stall), one byte per
// transaction, with last_byte marking the end of each haystack. Exactly one
// transaction leaves on the result channel per haystack: found with the start
// offset at the first match, or not found with offset 0 on the last byte.
// The needle, its length and case folding are written over the cfg channel,
// which is always ready; write it only while no byte is in flight.
// Each byte is held in the input register while it is compared against the
// needle, and its result is captured in the result register.
// Throughput: one byte per cycle while the receiver does not stall; the new
// byte and the byte window are compared against the needle combinationally,
// between the input and result registers.
// When the receiver stalls, the result register holds; the input register
// keeps accepting until it also holds a byte, then stall goes back upstream.
// Reset clears configuration to zero, empties both registers and clears the
// window, byte counter and answered flag.
// ----------------------------------------------------------------------------
module substring_first_match_search_top
#(
    parameter int MAX_NEEDLE  = 16,
    parameter int OFFSET_BITS = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 haystack_valid,
    output logic                                 haystack_stall,
    input  sfms_pkg::haystack_t                  haystack,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output sfms_pkg::result_t                    result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sfms_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sfms_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    sfms_pkg::cfg_t      cfg;
    sfms_pkg::haystack_t item;
    sfms_pkg::result_t   res;
    logic                fire;
    logic                emit;
    logic                advance;

    sfms_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfms_in_reg u_in_reg
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .haystack_valid (haystack_valid),
        .haystack_stall (haystack_stall),
        .haystack       (haystack),
        .advance        (advance),
        .fire           (fire),
        .item           (item)
    );

    sfms_core
    #(
        .MAX_NEEDLE  (MAX_NEEDLE),
        .OFFSET_BITS (OFFSET_BITS)
    )
    u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (fire),
        .item  (item),
        .emit  (emit),
        .res   (res)
    );

    sfms_out_reg u_out_reg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .emit         (emit),
        .res          (res),
        .advance      (advance),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming first-match substring search.
// ----------------------------------------------------------------------------
// Drives haystacks byte by byte and predicts each answer in a scoreboard that
// keeps its own needle, byte window, counter and answered flag. A short
// directed run opens. Random haystacks follow, built around the needle, some
// with one byte corrupted or cut short. Both channels idle at random in
// several phases. The needle registers are rewritten between haystacks, and
// now and then in the middle of one, once the pipeline has drained.
// ----------------------------------------------------------------------------
module testbench;

    class first_match_predictor;
        logic [sfms_pkg::NEEDLE_BITS-1:0] needle_bits;
        logic [sfms_pkg::LEN_BITS-1:0]    needle_len;
        logic                             fold_on;
        logic [7:0]                       window[sfms_pkg::NEEDLE_CAP-1];
        logic [31:0]                      seen;
        bit                               answered;
        sfms_pkg::result_t                expected_answers[$];
        int                               mismatches;
        int                               live_bytes;

        function new();
            needle_bits = '0;
            needle_len  = '0;
            fold_on     = 1'b0;
            mismatches  = 0;
            live_bytes  = 0;
            forget_haystack();
        endfunction

        function void forget_haystack();
            foreach (window[i])
            begin
                window[i] = 8'h00;
            end
            seen     = '0;
            answered = 1'b0;
        endfunction

        function void write_register(logic [sfms_pkg::CFG_INDEX_BITS-1:0] idx,
                                     logic [sfms_pkg::CFG_DATA_BITS-1:0] value);
            case (idx)
                sfms_pkg::CFG_NEEDLE_LOW:    needle_bits[63:0]   = value;
                sfms_pkg::CFG_NEEDLE_HIGH:   needle_bits[127:64] = value;
                sfms_pkg::CFG_NEEDLE_LENGTH: needle_len = value[sfms_pkg::LEN_BITS-1:0];
                sfms_pkg::CFG_CASE_FOLD:     fold_on             = value[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] lowered(logic [7:0] c);
            if (fold_on && c >= sfms_pkg::UPPER_FIRST && c <= sfms_pkg::UPPER_LAST)
            begin
                return c + sfms_pkg::CASE_SHIFT;
            end
            return c;
        endfunction

        function void take_byte(sfms_pkg::haystack_t item);
            int                span;
            int                k;
            bit                hit;
            logic [31:0]       off;
            sfms_pkg::result_t answer;
            span = (needle_len > sfms_pkg::NEEDLE_CAP) ? sfms_pkg::NEEDLE_CAP
                                                       : int'(needle_len);
            live_bytes++;
            if (!answered)
            begin
                hit = 1'b0;
                off = '0;
                if (span == 0)
                begin
                    hit = 1'b1;
                end
                else if (seen >= span - 1)
                begin
                    // newest byte against the needle tail, window against the rest
                    hit = lowered(item.data_byte) == needle_bits[8*(span-1) +: 8];
                    for (k = 1; k < span; k++)
                    begin
                        if (lowered(window[k-1]) != needle_bits[8*(span-1-k) +: 8])
                        begin
                            hit = 1'b0;
                        end
                    end
                    off = seen - (span - 1);
                end
                if (hit)
                begin
                    answer.found        = 1'b1;
                    answer.match_offset = off;
                    expected_answers.push_back(answer);
                    answered = 1'b1;
                end
                else if (item.last_byte)
                begin
                    answer.found        = 1'b0;
                    answer.match_offset = '0;
                    expected_answers.push_back(answer);
                end
            end
            if (item.last_byte)
            begin
                forget_haystack();
            end
            else
            begin
                for (k = sfms_pkg::NEEDLE_CAP - 2; k > 0; k--)
                begin
                    window[k] = window[k-1];
                end
                window[0] = item.data_byte;
                if (seen != '1)
                begin
                    seen++;
                end
            end
        endfunction

        function void compare_answer(sfms_pkg::result_t got);
            sfms_pkg::result_t want;
            if (expected_answers.size() == 0)
            begin
                $display("%0t: result expected none actual found=%0b offset=%0d",
                         $time, got.found, got.match_offset);
                mismatches++;
                return;
            end
            want = expected_answers.pop_front();
            if (got.found !== want.found)
            begin
                $display("%0t: found expected %0b actual %0b",
                         $time, want.found, got.found);
                mismatches++;
            end
            if (got.match_offset !== want.match_offset)
            begin
                $display("%0t: match_offset expected %0d actual %0d",
                         $time, want.match_offset, got.match_offset);
                mismatches++;
            end
        endfunction
    endclass

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_BYTES = 1450;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                haystack_valid = 1'b0;
    logic                                haystack_stall;
    sfms_pkg::haystack_t                 haystack = '0;
    logic                                result_valid;
    logic                                result_stall = 1'b0;
    sfms_pkg::result_t                   result;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [sfms_pkg::CFG_INDEX_BITS-1:0] cfg_index = sfms_pkg::CFG_NEEDLE_LOW;
    logic [sfms_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles = 0;

    // register image on the stimulus side
    logic [sfms_pkg::NEEDLE_BITS-1:0] needle_word = '0;
    logic [sfms_pkg::LEN_BITS-1:0]    len_reg = '0;
    logic                             fold_reg = 1'b0;
    logic [7:0]                       hay_bytes[$];

    first_match_predictor answers;

    substring_first_match_search_top DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .haystack_valid (haystack_valid),
        .haystack_stall (haystack_stall),
        .haystack       (haystack),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            answers.compare_answer(result);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (haystack_valid && !haystack_stall) ||
            (result_valid && !result_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int stim_span();
        return (len_reg > sfms_pkg::NEEDLE_CAP) ? sfms_pkg::NEEDLE_CAP : int'(len_reg);
    endfunction

    // Hide a needle letter as a capital when folding is on
    function automatic logic [7:0] disguise(logic [7:0] b);
        if (fold_reg && b >= 8'h61 && b <= 8'h7A && $urandom_range(1) == 1)
        begin
            return b - sfms_pkg::CASE_SHIFT;
        end
        return b;
    endfunction

    function automatic logic [7:0] pick_byte();
        int span;
        span = stim_span();
        case ($urandom_range(3))
            0: return 8'($urandom_range(255));
            1: return (span > 0) ? disguise(needle_word[8*$urandom_range(span-1) +: 8])
                                 : 8'($urandom_range(255));
            2: return 8'h61 + 8'($urandom_range(3));
            default: return sfms_pkg::UPPER_FIRST + 8'($urandom_range(3));
        endcase
    endfunction

    task automatic write_register(input logic [sfms_pkg::CFG_INDEX_BITS-1:0] idx,
                                  input logic [sfms_pkg::CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        answers.write_register(idx, value);
    endtask

    // Write the whole register image; junk rides in the unused upper bits
    task automatic apply_settings();
        write_register(sfms_pkg::CFG_NEEDLE_LOW, needle_word[63:0]);
        write_register(sfms_pkg::CFG_NEEDLE_HIGH, needle_word[127:64]);
        write_register(sfms_pkg::CFG_NEEDLE_LENGTH,
                       {$urandom, 27'($urandom), len_reg});
        write_register(sfms_pkg::CFG_CASE_FOLD, {$urandom, 31'($urandom), fold_reg});
        cfg_valid <= 1'b0;
    endtask

    task automatic choose_settings();
        int style;
        int k;
        case ($urandom_range(7))
            0: len_reg = 5'd0;
            1: len_reg = 5'd1;
            2: len_reg = 5'd16;
            3: len_reg = 5'($urandom_range(17, 31));
            default: len_reg = 5'($urandom_range(2, 6));
        endcase
        style = $urandom_range(9);
        for (k = 0; k < sfms_pkg::NEEDLE_CAP; k++)
        begin
            if (style == 0)
                needle_word[8*k +: 8] = 8'h00;
            else if (style == 1)
                needle_word[8*k +: 8] = 8'hFF;
            else if (style == 2 || $urandom_range(7) == 0)
                needle_word[8*k +: 8] = 8'($urandom_range(255));
            else
                needle_word[8*k +: 8] = 8'h61 + 8'($urandom_range(3));
        end
        fold_reg = 1'($urandom_range(1));
    endtask

    task automatic send_byte(input logic [7:0] b, input bit last);
        sfms_pkg::haystack_t item;
        item.data_byte = b;
        item.last_byte = last;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            haystack_valid <= 1'b0;
            @(posedge clk);
        end
        haystack_valid <= 1'b1;
        haystack       <= item;
        @(posedge clk);
        while (haystack_stall)
        begin
            @(posedge clk);
        end
        answers.take_byte(item);
    endtask

    // Hold off until every answer is in, then let bytes with no answer drain
    task automatic settle_pipeline();
        haystack_valid <= 1'b0;
        while (answers.expected_answers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic build_haystack();
        int span;
        int n;
        int p;
        int k;
        int mode;
        span = stim_span();
        n = ($urandom_range(11) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 20);
        hay_bytes.delete();
        repeat (n) hay_bytes.push_back(pick_byte());
        mode = $urandom_range(99);
        if (span > 0 && mode < 70)
        begin
            while (hay_bytes.size() < span)
            begin
                hay_bytes.push_back(pick_byte());
            end
            p = $urandom_range(0, hay_bytes.size() - span);
            for (k = 0; k < span; k++)
            begin
                hay_bytes[p+k] = disguise(needle_word[8*k +: 8]);
            end
            if (mode >= 55)
            begin
                if (span > 1 && $urandom_range(1) == 1)
                begin
                    // cut the haystack one byte short of the match
                    while (hay_bytes.size() > p + span - 1)
                    begin
                        void'(hay_bytes.pop_back());
                    end
                end
                else
                begin
                    k = $urandom_range(0, span - 1);
                    hay_bytes[p+k] = hay_bytes[p+k] ^ 8'($urandom_range(1, 255));
                end
            end
        end
    endtask

    task automatic send_haystack();
        int i;
        int cut;
        cut = -1;
        if (hay_bytes.size() > 1 && $urandom_range(29) == 0)
        begin
            cut = $urandom_range(1, hay_bytes.size() - 1);
        end
        for (i = 0; i < hay_bytes.size(); i++)
        begin
            if (i == cut)
            begin
                settle_pipeline();
                if ($urandom_range(1) == 1)
                begin
                    len_reg = 5'($urandom_range(31));
                    write_register(sfms_pkg::CFG_NEEDLE_LENGTH,
                                   {59'($urandom), len_reg});
                end
                else
                begin
                    fold_reg = !fold_reg;
                    write_register(sfms_pkg::CFG_CASE_FOLD, {63'($urandom), fold_reg});
                end
                cfg_valid <= 1'b0;
            end
            send_byte(hay_bytes[i], i == hay_bytes.size() - 1);
        end
    endtask

    initial
    begin
        int base;
        int phase;
        int hay_count;
        int k;
        answers = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty needle after reset: answer on the first byte, ignore the rest
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h41, 1'b1);
        settle_pipeline();

        needle_word = {64'h0, 64'h6261};
        len_reg     = 5'd2;
        fold_reg    = 1'b1;
        apply_settings();
        send_byte(8'h78, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);
        // shorter than the needle
        send_byte(8'h61, 1'b1);
        // drop folding part way through: the held capital is no longer lowered
        send_byte(8'h78, 1'b0);
        send_byte(8'h41, 1'b0);
        settle_pipeline();
        fold_reg = 1'b0;
        write_register(sfms_pkg::CFG_CASE_FOLD, {63'h0, fold_reg});
        cfg_valid <= 1'b0;
        send_byte(8'h42, 1'b1);
        settle_pipeline();

        // oversized length saturates to a full sixteen byte needle
        needle_word = '1;
        len_reg     = 5'd31;
        apply_settings();
        for (k = 0; k < sfms_pkg::NEEDLE_CAP; k++)
        begin
            send_byte(8'hFF, k == sfms_pkg::NEEDLE_CAP - 1);
        end
        settle_pipeline();

        base = answers.live_bytes;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
                default: begin sender_idle_pct = 32; receiver_stall_pct = 32; end
            endcase
            hay_count = 0;
            while (answers.live_bytes < base + RANDOM_BYTES * (phase + 1) / 4)
            begin
                if (hay_count % 12 == 0)
                begin
                    settle_pipeline();
                    choose_settings();
                    apply_settings();
                end
                build_haystack();
                send_haystack();
                hay_count++;
            end
        end

        haystack_valid <= 1'b0;
        while (answers.expected_answers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (answers.mismatches == 0 && answers.expected_answers.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            foreach (answers.expected_answers[i])
            begin
                $display("%0t: missing result, expected found=%0b offset=%0d", $time,
                         answers.expected_answers[i].found,
                         answers.expected_answers[i].match_offset);
            end
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
